// ----- src/lwoi_pkg.sv -----
package lwoi_pkg;

    // Default sizing of the index.
    localparam int NUM_REFS_DEF     = 16;
    localparam int MAX_WINDOWS_DEF  = 8192;
    localparam int WINDOW_SHIFT_DEF = 13;

    // Field widths of one input word and one result word.
    localparam int REF_W    = 4;
    localparam int POS_W    = 29;
    localparam int LEN_W    = 16;
    localparam int OFF_W    = 64;
    localparam int STATUS_W = 3;

    // Input tdata layout, lowest bit first: ref_id, position, ref_length, file_offset.
    localparam int REF_LSB   = 0;
    localparam int POS_LSB   = REF_LSB + REF_W;
    localparam int LEN_LSB   = POS_LSB + POS_W;
    localparam int OFF_LSB   = LEN_LSB + LEN_W;
    localparam int IN_DATA_W = ((OFF_LSB + OFF_W + 7) / 8) * 8;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_QUERY_OK = 3'd1,
        ST_ORDER    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_REJECTED = 3'd5
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic decode;
        logic rd;
        logic ins_chk;
        logic q_chk;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic dec_ins;
        logic dec_qry;
        logic ins_last;
        logic q_done;
        logic out_busy;
    } t_stat;

endpackage

// ----- src/lwoi_ram.sv -----
module lwoi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/lwoi_ctrl.sv -----
module lwoi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  lwoi_pkg::t_stat  i_stat,
    output lwoi_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_CHK,
        S_Q_RD,
        S_Q_CHK,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.dec_ins) begin
                    n_state = S_INS_RD;
                end else if (i_stat.dec_qry) begin
                    n_state = S_Q_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_INS_RD:  n_state = S_INS_CHK;
            S_INS_CHK: n_state = i_stat.ins_last ? S_FINISH : S_INS_RD;
            S_Q_RD:    n_state = S_Q_CHK;
            S_Q_CHK:   n_state = i_stat.q_done ? S_FINISH : S_Q_RD;
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_CLEAR;
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_step = (r_state == S_CLEAR);
        o_cmd.accept   = r_ready && i_s_tvalid;
        o_cmd.decode   = (r_state == S_DECODE);
        o_cmd.rd       = (r_state == S_INS_RD) || (r_state == S_Q_RD);
        o_cmd.ins_chk  = (r_state == S_INS_CHK);
        o_cmd.q_chk    = (r_state == S_Q_CHK);
        o_cmd.finish   = (r_state == S_FINISH) && !i_stat.out_busy;
    end

    assign o_s_tready = r_ready;

endmodule

// ----- src/lwoi_dp.sv -----
module lwoi_dp #(
    parameter int NUM_REFS     = lwoi_pkg::NUM_REFS_DEF,
    parameter int MAX_WINDOWS  = lwoi_pkg::MAX_WINDOWS_DEF,
    parameter int WINDOW_SHIFT = lwoi_pkg::WINDOW_SHIFT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lwoi_pkg::t_cmd                 i_cmd,
    output lwoi_pkg::t_stat                o_stat,
    input  logic [lwoi_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic [0:0]                     i_s_tuser,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [lwoi_pkg::OFF_W-1:0]     o_m_tdata,
    output logic [lwoi_pkg::STATUS_W-1:0]  o_m_tuser
);

    localparam int REF_W    = lwoi_pkg::REF_W;
    localparam int POS_W    = lwoi_pkg::POS_W;
    localparam int LEN_W    = lwoi_pkg::LEN_W;
    localparam int OFF_W    = lwoi_pkg::OFF_W;
    localparam int DEPTH    = NUM_REFS * MAX_WINDOWS;
    localparam int ADDR_W   = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int WIN_W    = MAX_WINDOWS > 1 ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W    = $clog2(MAX_WINDOWS + 1);
    localparam int END_W    = POS_W + 1;
    localparam int LAST_W   = END_W - WINDOW_SHIFT;
    localparam int START_W  = POS_W - WINDOW_SHIFT;
    localparam int NUM_CNT  = NUM_REFS < (1 << REF_W) ? NUM_REFS : (1 << REF_W);
    localparam int CIDX_W   = NUM_CNT > 1 ? $clog2(NUM_CNT) : 1;
    localparam int CNT_DEPTH = 1 << CIDX_W;

    // Input field slices.
    logic [REF_W-1:0] w_in_ref;
    logic [POS_W-1:0] w_in_pos;
    logic [LEN_W-1:0] w_in_len;
    logic [LEN_W-1:0] w_len1;
    logic [END_W-1:0] w_end;

    assign w_in_ref = i_s_tdata[lwoi_pkg::REF_LSB +: REF_W];
    assign w_in_pos = i_s_tdata[lwoi_pkg::POS_LSB +: POS_W];
    assign w_in_len = i_s_tdata[lwoi_pkg::LEN_LSB +: LEN_W];
    assign w_len1   = (w_in_len == '0) ? LEN_W'(1) : w_in_len;
    assign w_end    = END_W'(w_in_pos) + END_W'(w_len1) - END_W'(1);

    // Latched item.
    logic              r_mode;
    logic [REF_W-1:0]  r_ref;
    logic [POS_W-1:0]  r_pos;
    logic [OFF_W-1:0]  r_off;
    logic [LAST_W-1:0] r_last;
    logic [ADDR_W-1:0] r_base;

    // Order tracking and window counts.
    logic              r_err;
    logic              r_have_prev;
    logic [REF_W-1:0]  r_prev_ref;
    logic [POS_W-1:0]  r_prev_pos;
    logic [CNT_W-1:0]  r_cnt [CNT_DEPTH];

    // Walk state.
    logic [WIN_W-1:0]  r_win;
    logic [WIN_W-1:0]  r_nm1;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_clr;
    lwoi_pkg::t_status r_res_status;
    logic [OFF_W-1:0]  r_res_off;

    // Output register.
    logic              r_out_valid;
    lwoi_pkg::t_status r_out_status;
    logic [OFF_W-1:0]  r_out_off;

    logic [OFF_W-1:0]  w_rdata;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [OFF_W-1:0]  w_ram_wdata;

    logic [START_W-1:0] w_first;
    logic [CNT_W-1:0]   w_n;
    logic [WIN_W-1:0]   w_nm1;
    logic               w_ref_bad;
    logic               w_ord_bad;
    logic               w_win_bad;
    logic               w_start_past;
    logic               w_dec_ins;
    logic               w_dec_qry;
    logic [WIN_W-1:0]   w_dec_win;
    lwoi_pkg::t_status  w_dec_status;
    logic               w_ins_last;
    logic               w_q_done;

    assign w_first      = r_pos[POS_W-1:WINDOW_SHIFT];
    assign w_n          = r_cnt[r_ref[CIDX_W-1:0]];
    assign w_nm1        = WIN_W'(w_n - CNT_W'(1));
    assign w_ref_bad    = 32'(r_ref) >= NUM_REFS;
    assign w_ord_bad    = r_have_prev && (r_ref == r_prev_ref) && (r_pos < r_prev_pos);
    assign w_win_bad    = 32'(r_last) >= MAX_WINDOWS;
    assign w_start_past = 32'(w_first) >= 32'(w_n);
    assign w_dec_ins    = !r_err && (r_mode == lwoi_pkg::MODE_INSERT)
                          && !w_ord_bad && !w_ref_bad && !w_win_bad;
    assign w_dec_qry    = !r_err && (r_mode == lwoi_pkg::MODE_QUERY)
                          && !w_ref_bad && (w_n != '0);
    assign w_ins_last   = (r_win == WIN_W'(r_last));
    assign w_q_done     = (w_rdata != '0) || (r_win == r_nm1);

    always_comb begin
        if (w_dec_ins || !w_start_past) begin
            w_dec_win = WIN_W'(w_first);
        end else begin
            w_dec_win = w_nm1;
        end
        if (r_err) begin
            w_dec_status = lwoi_pkg::ST_REJECTED;
        end else if (r_mode == lwoi_pkg::MODE_QUERY) begin
            w_dec_status = lwoi_pkg::ST_EMPTY;
        end else if (w_ord_bad) begin
            w_dec_status = lwoi_pkg::ST_ORDER;
        end else begin
            w_dec_status = lwoi_pkg::ST_OVERFLOW;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_s_tuser[0];
            r_ref  <= w_in_ref;
            r_pos  <= w_in_pos;
            r_off  <= i_s_tdata[lwoi_pkg::OFF_LSB +: OFF_W];
            r_last <= w_end[END_W-1:WINDOW_SHIFT];
            r_base <= ADDR_W'(32'(w_in_ref) * MAX_WINDOWS);
        end
        if (i_cmd.decode) begin
            r_win        <= w_dec_win;
            r_nm1        <= w_nm1;
            r_addr       <= r_base + ADDR_W'(w_dec_win);
            r_res_status <= w_dec_status;
            r_res_off    <= '0;
        end
        if (i_cmd.ins_chk) begin
            if (w_ins_last) begin
                r_res_status <= lwoi_pkg::ST_INSERTED;
            end else begin
                r_win  <= r_win + WIN_W'(1);
                r_addr <= r_addr + ADDR_W'(1);
            end
        end
        if (i_cmd.q_chk) begin
            if (w_q_done) begin
                r_res_status <= lwoi_pkg::ST_QUERY_OK;
                r_res_off    <= w_rdata;
            end else begin
                r_win  <= r_win + WIN_W'(1);
                r_addr <= r_addr + ADDR_W'(1);
            end
        end
        if (i_cmd.finish) begin
            r_out_status <= r_res_status;
            r_out_off    <= r_res_off;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err       <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev_ref  <= '0;
            r_prev_pos  <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CNT_DEPTH; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd.decode && !r_err && (r_mode == lwoi_pkg::MODE_INSERT)) begin
                if (w_ord_bad) begin
                    r_err <= 1'b1;
                end else begin
                    r_have_prev <= 1'b1;
                    r_prev_ref  <= r_ref;
                    r_prev_pos  <= r_pos;
                end
            end
            if (i_cmd.ins_chk && w_ins_last && (32'(w_n) < 32'(r_last) + 1)) begin
                r_cnt[r_ref[CIDX_W-1:0]] <= CNT_W'(r_last + LAST_W'(1));
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The clearing pass and the insert walk share the single write port.
    assign w_ram_we    = i_cmd.clr_step || (i_cmd.ins_chk && (w_rdata == '0));
    assign w_ram_waddr = i_cmd.clr_step ? r_clr : r_addr;
    assign w_ram_wdata = i_cmd.clr_step ? '0 : r_off;

    lwoi_ram #(
        .WIDTH (OFF_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_stat          = '0;
        o_stat.clr_last = (r_clr == ADDR_W'(DEPTH - 1));
        o_stat.dec_ins  = w_dec_ins;
        o_stat.dec_qry  = w_dec_qry;
        o_stat.ins_last = w_ins_last;
        o_stat.q_done   = w_q_done;
        o_stat.out_busy = r_out_valid && !i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_off;
    assign o_m_tuser  = r_out_status;

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("ordering error flag dropped without reset");

    a_ins_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_chk |-> (32'(r_win) <= 32'(r_last)))
        else $error("insert walk passed its last window");

    a_q_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.q_chk |-> (r_win <= r_nm1))
        else $error("query scan passed the filled count");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != lwoi_pkg::ST_QUERY_OK)) |-> (r_out_off == '0))
        else $error("nonzero offset on a result that is not a query hit");

endmodule

// ----- src/linear_window_offset_index.sv -----
// Channel   Dir  Handshake              Payload
// s (item)  in   i_s_tvalid/o_s_tready  i_s_tuser = mode, i_s_tdata = ref_id .. file_offset
// m (res)   out  o_m_tvalid/i_m_tready  o_m_tuser = status, o_m_tdata = found_offset
//
// After reset the offset memory is swept to zero, one entry a cycle, over all
// NUM_REFS*MAX_WINDOWS entries (131072 at the defaults); no word is accepted meanwhile.
// A word is accepted, decoded, walked over its windows and finished: an insert reads
// each covered window once (one to nine at the defaults), a query reads windows from
// its start until a filled one or the last counted window, and error results read
// none. Each window is read and then checked, as the memory's read data is registered.
// Reset is synchronous and active low. A finished result sits in an output register,
// so the next word is taken while it waits; the block stalls only when a second
// result is ready before the first has been taken.
module linear_window_offset_index #(
    parameter int NUM_REFS     = lwoi_pkg::NUM_REFS_DEF,
    parameter int MAX_WINDOWS  = lwoi_pkg::MAX_WINDOWS_DEF,
    parameter int WINDOW_SHIFT = lwoi_pkg::WINDOW_SHIFT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // ref_id [3:0], position [32:4], ref_length [48:33], file_offset [112:49], zero pad.
    input  logic [lwoi_pkg::IN_DATA_W-1:0] i_s_tdata,
    // mode [0]: 0 insert, 1 query.
    input  logic [0:0]                     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // found_offset [63:0].
    output logic [lwoi_pkg::OFF_W-1:0]     o_m_tdata,
    // status [2:0].
    output logic [lwoi_pkg::STATUS_W-1:0]  o_m_tuser
);

    // The controller only sequences; every decision on data comes back as status.
    lwoi_pkg::t_cmd  w_cmd;
    lwoi_pkg::t_stat w_stat;

    lwoi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lwoi_dp #(
        .NUM_REFS     (NUM_REFS),
        .MAX_WINDOWS  (MAX_WINDOWS),
        .WINDOW_SHIFT (WINDOW_SHIFT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ----- bench/linear_window_offset_index_tb.sv -----
module linear_window_offset_index_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lwoi_pkg::*;

    localparam logic [POS_W-1:0] MAX_POS = {POS_W{1'b1}};
    // Lowest position whose window lies past the last one of a reference.
    localparam logic [POS_W-1:0] OVF_POS = POS_W'(MAX_WINDOWS_DEF) << WINDOW_SHIFT_DEF;
    localparam logic [POS_W-1:0] TOP_WIN_POS = POS_W'(MAX_WINDOWS_DEF - 1) << WINDOW_SHIFT_DEF;
    localparam int LOOKUP_ITEMS = 1500;
    // Rows of the directed table that run before the random part; the rest break the
    // record order, which only reset could undo, so they close the run.
    localparam int OPEN_ROWS = 19;
    localparam int ROW_COUNT = 23;

    // One result word as the block should deliver it.
    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] found;
    } index_answer_t;

    // One directed word; where typed is set, the expected result is written in the row.
    typedef struct packed {
        logic             mode;
        logic [REF_W-1:0] rid;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic [OFF_W-1:0] off;
        logic             typed;
        t_status          status;
        logic [OFF_W-1:0] found;
    } directed_word_t;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [IN_DATA_W-1:0] i_s_tdata = '0;
    logic [0:0]           i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [OFF_W-1:0]     o_m_tdata;
    logic [STATUS_W-1:0]  o_m_tuser;

    // Shadow copy of the index: window offsets, filled-window counts and the
    // order-check memory of the last accepted insert.
    bit [OFF_W-1:0]   win_store [NUM_REFS_DEF][MAX_WINDOWS_DEF];
    int unsigned      fill_count [NUM_REFS_DEF];
    bit               seen_insert;
    bit [REF_W-1:0]   prev_ref;
    bit [POS_W-1:0]   prev_pos;
    bit               order_broken;

    index_answer_t    pending_answers [$];
    int               error_count;
    // High while both sides run without idle cycles.
    bit               steady;

    linear_window_offset_index u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one accepted word to the shadow index and returns the result it earns.
    function automatic index_answer_t lookup_step(input logic mode, input logic [REF_W-1:0] rid,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [LEN_W-1:0] len,
                                                  input logic [OFF_W-1:0] off);
        index_answer_t   ans;
        longint unsigned first_win;
        longint unsigned last_win;
        longint unsigned span;
        longint unsigned w;
        ans.status = ST_INSERTED;
        ans.found = '0;
        if (order_broken) begin
            ans.status = ST_REJECTED;
        end else if (mode == MODE_INSERT) begin
            if (seen_insert && rid == prev_ref && pos < prev_pos) begin
                order_broken = 1'b1;
                ans.status = ST_ORDER;
            end else begin
                // Even an insert that overflows becomes the reference for the order check.
                seen_insert = 1'b1;
                prev_ref = rid;
                prev_pos = pos;
                span = (len == 0) ? 64'd1 : 64'(len);
                first_win = longint'(pos) >> WINDOW_SHIFT_DEF;
                last_win = (longint'(pos) + span - 1) >> WINDOW_SHIFT_DEF;
                if (last_win >= MAX_WINDOWS_DEF) begin
                    ans.status = ST_OVERFLOW;
                end else begin
                    // Only empty windows take the offset, so an offset of zero
                    // leaves them empty.
                    for (w = first_win; w <= last_win; w++) begin
                        if (win_store[rid][w] == 0) win_store[rid][w] = off;
                    end
                    if (fill_count[rid] < last_win + 1) fill_count[rid] = 32'(last_win + 1);
                end
            end
        end else if (fill_count[rid] == 0) begin
            ans.status = ST_EMPTY;
        end else begin
            // Scan for the first filled window; past the count, fall back to the last one.
            w = longint'(pos) >> WINDOW_SHIFT_DEF;
            while (w < fill_count[rid] && win_store[rid][w] == 0) w++;
            ans.status = ST_QUERY_OK;
            ans.found = (w >= fill_count[rid]) ? win_store[rid][fill_count[rid] - 1]
                                               : win_store[rid][w];
        end
        return ans;
    endfunction

    // Presents one word, waits for the handshake and queues the result it should cause.
    task automatic send_word(input logic mode, input logic [REF_W-1:0] rid,
                             input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len,
                             input logic [OFF_W-1:0] off, input logic typed,
                             input t_status typed_status, input logic [OFF_W-1:0] typed_found);
        logic [IN_DATA_W-1:0] payload;
        index_answer_t        ans;
        payload = '0;
        payload[REF_LSB +: REF_W] = rid;
        payload[POS_LSB +: POS_W] = pos;
        payload[LEN_LSB +: LEN_W] = len;
        payload[OFF_LSB +: OFF_W] = off;
        while (!steady && $urandom_range(0, 99) < 37) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= payload;
        i_s_tuser <= mode;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        ans = lookup_step(mode, rid, pos, len, off);
        if (typed) begin
            ans.status = typed_status;
            ans.found = typed_found;
        end
        pending_answers.push_back(ans);
    endtask

    // Result side: check every word taken, then pick the ready level for the next edge.
    always @(posedge i_clk) begin
        index_answer_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_answers.size() == 0) begin
                $error("result word with no expectation: status %0d, found_offset %h",
                       o_m_tuser, o_m_tdata);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_m_tuser);
                    error_count++;
                end
                if (o_m_tdata !== want.found) begin
                    $error("found_offset: expected %h, actual %h", want.found, o_m_tdata);
                    error_count++;
                end
            end
        end
        i_m_tready <= steady || ($urandom_range(0, 99) >= 37);
    end

    initial begin
        directed_word_t  rows [ROW_COUNT];
        logic            mode;
        logic [REF_W-1:0] rid;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic [OFF_W-1:0] off;
        longint unsigned step_pos;
        int              pick;

        rows = '{
            // A query straight after reset finds nothing.
            '{MODE_QUERY,  4'd0,  29'd0,        16'd0,     64'd0,
              1'b1, ST_EMPTY,    64'd0},
            // Zero length counts as one position.
            '{MODE_INSERT, 4'd0,  29'd0,        16'd0,     64'd1,
              1'b1, ST_INSERTED, 64'd0},
            '{MODE_QUERY,  4'd0,  29'd0,        16'd0,     64'd0,
              1'b1, ST_QUERY_OK, 64'd1},
            // Straddles windows 0 and 1; window 0 keeps its first offset.
            '{MODE_INSERT, 4'd0,  29'd8191,     16'd2,     64'h0123_4567_89ab_cdef,
              1'b1, ST_INSERTED, 64'd0},
            '{MODE_QUERY,  4'd0,  29'd8192,     16'd0,     64'd0,
              1'b1, ST_QUERY_OK, 64'h0123_4567_89ab_cdef},
            // Start window far past the count returns the last filled window.
            '{MODE_QUERY,  4'd0,  MAX_POS,      16'hffff,  {OFF_W{1'b1}},
              1'b1, ST_QUERY_OK, 64'h0123_4567_89ab_cdef},
            // Longest record: nine windows at once.
            '{MODE_INSERT, 4'd1,  29'd100,      16'hffff,  {OFF_W{1'b1}},
              1'b1, ST_INSERTED, 64'd0},
            '{MODE_QUERY,  4'd1,  29'd40960,    16'd0,     64'd0,
              1'b1, ST_QUERY_OK, {OFF_W{1'b1}}},
            // An offset of zero counts the window but leaves it empty.
            '{MODE_INSERT, 4'd2,  29'd0,        16'd1,     64'd0,
              1'b1, ST_INSERTED, 64'd0},
            '{MODE_QUERY,  4'd2,  29'd0,        16'd0,     64'd0,
              1'b1, ST_QUERY_OK, 64'd0},
            '{MODE_INSERT, 4'd2,  OVF_POS,      16'd1,     64'h00aa_00bb_00cc_00dd,
              1'b1, ST_OVERFLOW, 64'd0},
            '{MODE_INSERT, 4'd3,  MAX_POS,      16'hffff,  64'h00aa_00bb_00cc_00dd,
              1'b1, ST_OVERFLOW, 64'd0},
            // The top reference gets its first and its last window, nothing between.
            '{MODE_INSERT, 4'd15, 29'd0,        16'd1,     64'h8000_0000_0000_0001,
              1'b1, ST_INSERTED, 64'd0},
            '{MODE_INSERT, 4'd15, TOP_WIN_POS,  16'd8192,  64'h7fff_ffff_ffff_fffe,
              1'b1, ST_INSERTED, 64'd0},
            // Long scan over empty windows up to the last one.
            '{MODE_QUERY,  4'd15, 29'd8192,     16'd0,     64'd0,
              1'b1, ST_QUERY_OK, 64'h7fff_ffff_ffff_fffe},
            '{MODE_INSERT, 4'd15, TOP_WIN_POS + 29'd1, 16'd8192, 64'hdead_beef_0000_0001,
              1'b1, ST_OVERFLOW, 64'd0},
            '{MODE_QUERY,  4'd14, 29'd0,        16'd0,     64'd0,
              1'b1, ST_EMPTY,    64'd0},
            // Back to an earlier reference below its old position: no order check.
            '{MODE_INSERT, 4'd2,  29'd5,        16'd0,     64'h0f0f_0f0f_f0f0_f0f0,
              1'b0, ST_INSERTED, 64'd0},
            '{MODE_QUERY,  4'd2,  29'd0,        16'd0,     64'd0,
              1'b0, ST_INSERTED, 64'd0},
            // Closing rows: break the record order, then everything is rejected.
            '{MODE_INSERT, 4'd4,  MAX_POS,      16'd1,     64'd7,
              1'b1, ST_OVERFLOW, 64'd0},
            '{MODE_INSERT, 4'd4,  29'd0,        16'd1,     64'd7,
              1'b1, ST_ORDER,    64'd0},
            '{MODE_QUERY,  4'd0,  29'd0,        16'd0,     64'd0,
              1'b1, ST_REJECTED, 64'd0},
            '{MODE_INSERT, 4'd1,  MAX_POS,      16'd1,     64'd9,
              1'b1, ST_REJECTED, 64'd0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block sweeps its memory after reset; the first handshake waits for that.
        for (int i = 0; i < OPEN_ROWS; i++) begin
            send_word(rows[i].mode, rows[i].rid, rows[i].pos, rows[i].len, rows[i].off,
                      rows[i].typed, rows[i].status, rows[i].found);
        end

        // Random part: an insert on the same reference as the last insert never moves below
        // its position, so the sticky error is never hit here. Reference 15 is kept out because
        // its sparse windows make most queries on it a long scan.
        for (int n = 0; n < LOOKUP_ITEMS; n++) begin
            steady = (n >= 600 && n < 900);
            pick = $urandom_range(0, 99);
            len = LEN_W'($urandom);
            off = {$urandom, $urandom};
            if (pick < 40) begin
                mode = MODE_QUERY;
                rid = REF_W'($urandom_range(0, 14));
                pos = ($urandom_range(0, 99) < 85) ? POS_W'($urandom_range(0, (1 << 20) - 1))
                                                   : POS_W'($urandom);
            end else begin
                mode = MODE_INSERT;
                if (seen_insert && prev_ref != 4'd15 && $urandom_range(0, 99) < 55) begin
                    rid = prev_ref;
                end else begin
                    rid = REF_W'($urandom_range(0, 14));
                end
                if (seen_insert && rid == prev_ref) begin
                    if ($urandom_range(0, 99) < 4) begin
                        pos = POS_W'($urandom_range(MAX_POS,
                                                    (prev_pos > OVF_POS) ? prev_pos : OVF_POS));
                    end else begin
                        step_pos = longint'(prev_pos) + $urandom_range(0, 30000);
                        pos = (step_pos > MAX_POS) ? MAX_POS : POS_W'(step_pos);
                    end
                end else if ($urandom_range(0, 99) < 4) begin
                    pos = POS_W'($urandom_range(MAX_POS, OVF_POS));
                end else begin
                    pos = POS_W'($urandom_range(0, (1 << 19) - 1));
                end
                pick = $urandom_range(0, 99);
                if (pick < 10) len = '0;
                else if (pick < 15) len = '1;
                else if (pick < 70) len = LEN_W'($urandom_range(1, 200));
                if ($urandom_range(0, 99) < 6) off = '0;
            end
            send_word(mode, rid, pos, len, off, 1'b0, ST_INSERTED, '0);
        end
        steady = 1'b0;

        for (int i = OPEN_ROWS; i < ROW_COUNT; i++) begin
            send_word(rows[i].mode, rows[i].rid, rows[i].pos, rows[i].len, rows[i].off,
                      rows[i].typed, rows[i].status, rows[i].found);
        end
        i_s_tvalid <= 1'b0;

        // Drain, then leave room for any stray word the block might still produce.
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("linear_window_offset_index_tb: clean");
        end else begin
            $display("linear_window_offset_index_tb: errors");
        end
        $finish;
    end

    // Watchdog: the memory sweep plus every word is far below this.
    initial begin
        #30000000;
        $display("linear_window_offset_index_tb: errors");
        $finish;
    end

endmodule
